// ----- sv/bpaw_pkg.sv -----
package bpaw_pkg;

    localparam int IW = 48;

    localparam logic [23:0] P_GAIN_RST  = 24'd192000;
    localparam logic [19:0] I_GAIN_RST  = 20'd2304;
    localparam logic [23:0] D_GAIN_RST  = 24'd10240;
    localparam logic [14:0] CLIM_RST    = 15'd5000;
    localparam logic [13:0] TURN_RST    = 14'd1000;
    localparam logic [15:0] POFF_RST    = 16'd11520;
    localparam logic [7:0]  INIT_MS_RST = 8'd3;

    localparam logic [2:0] REG_P_GAIN  = 3'd0;
    localparam logic [2:0] REG_I_GAIN  = 3'd1;
    localparam logic [2:0] REG_D_GAIN  = 3'd2;
    localparam logic [2:0] REG_CLIM    = 3'd3;
    localparam logic [2:0] REG_TURN    = 3'd4;
    localparam logic [2:0] REG_POFF    = 3'd5;
    localparam logic [2:0] REG_INIT_MS = 3'd6;

    localparam logic [3:0] MODE_BWD3  = 4'd5;
    localparam logic [3:0] MODE_LEFT  = 4'd6;
    localparam logic [3:0] MODE_RIGHT = 4'd7;
    localparam logic [3:0] MODE_STILL = 4'd8;

    localparam logic signed [15:0] STILL_SNAP = 16'sd76;

    localparam logic signed [IW-1:0] INT_MAX48 = {1'b0, {(IW-1){1'b1}}};
    localparam logic signed [IW-1:0] INT_MIN48 = {1'b1, {(IW-1){1'b0}}};
    localparam logic [60:0] PROD_SAT = 61'h1000_0000_0000_0000;

    // ramp limit per drive mode, Q8 degrees
    function automatic logic signed [15:0] ramp_limit(input logic [3:0] m);
        case (m)
            4'd0, 4'd2: ramp_limit = -16'sd205;
            4'd1, 4'd3: ramp_limit = 16'sd384;
            4'd4:       ramp_limit = -16'sd640;
            4'd5:       ramp_limit = 16'sd640;
            default:    ramp_limit = 16'sd0;
        endcase
    endfunction

endpackage

// ----- sv/bpaw_mul.sv -----
// Bit-serial unsigned magnitude multiplier: one multiplier bit per cycle,
// saturates to PROD_SAT.
module bpaw_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [23:0] gain,
    input  logic [47:0] mag,
    output logic        done,
    output logic [60:0] prod
);
    logic [47:0] mag_reg, mag_next;
    logic [72:0] acc_reg, acc_next;
    logic [72:0] add_reg, add_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb begin
        mag_next  = mag_reg;
        acc_next  = acc_reg;
        add_next  = add_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            mag_next  = mag;
            acc_next  = '0;
            add_next  = {49'd0, gain};
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (mag_reg[0]) begin
                acc_next = acc_reg + add_reg;
            end
            add_next = add_reg << 1;
            mag_next = mag_reg >> 1;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        mag_reg <= mag_next;
        acc_reg <= acc_next;
        add_reg <= add_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign prod = (acc_reg > {12'd0, bpaw_pkg::PROD_SAT}) ? bpaw_pkg::PROD_SAT : acc_reg[60:0];
endmodule

// ----- sv/balance_pid_anti_windup_top.sv -----
// Balance PID with conditional-integration anti-windup.
// Input stream s_axis: one transaction per control tick, tdata carries
// pitch, gyro_rate, elapsed_ms and mode. Output stream m_axis: one
// transaction per input with drive_left, drive_right and restarted.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the seven registers;
// writes land at once and must be made only while the block is idle; the
// block itself does not enforce this. The three gain products run in
// parallel on bit-serial multipliers, one multiplier bit per cycle over 48
// bits; latch, integral update and multiplier start come before them, and
// sum, clamp/mode and output load come after them.
// One item is in flight at a time; s_axis_tready is high while idle, so a
// new transaction is taken only after the last result is loaded.
// A result sits in the output register until m_axis_tready takes it; the
// next item is still accepted and computed, then waits at the clamp/mode
// step until the output register frees, so input stalls behind it.
// Reset (aresetn low, synchronous) restores register defaults, clears the
// integrator, flags and angle target, sets the previous mode to stand-still
// and drops the output valid.
module balance_pid_anti_windup_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [16:0] pitch, [32:17] gyro_rate, [40:33] elapsed_ms, [44:41] mode
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] drive_left, [31:16] drive_right, [32] restarted
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INT  = 3'd1;
    localparam logic [2:0] ST_MST  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // configuration
    logic [23:0] p_gain_reg;
    logic [19:0] i_gain_reg;
    logic [23:0] d_gain_reg;
    logic [14:0] clim_reg;
    logic [13:0] turn_reg;
    logic [15:0] poff_reg;
    logic [7:0]  init_ms_reg;

    // loop state
    logic signed [47:0] integ_reg, integ_next;
    logic        was_sat_reg, was_sat_next;
    logic        same_reg, same_next;
    logic signed [15:0] target_reg, target_next;
    logic signed [15:0] rlim_reg, rlim_next;
    logic [3:0]  pmode_reg, pmode_next;
    logic        first_reg, first_next;

    logic [2:0]  state_reg, state_next;
    logic signed [16:0] pitch_reg, pitch_next;
    logic signed [15:0] gyro_reg, gyro_next;
    logic [7:0]  dt_reg, dt_next;
    logic [3:0]  mode_reg, mode_next;
    logic signed [17:0] err_reg, err_next;
    logic signed [64:0] sum_reg, sum_next;
    logic [39:0] out_reg, out_next;
    logic        ovalid_reg, ovalid_next;

    logic        mul_start;
    logic        done_p, done_i, done_d;
    logic [60:0] prod_p, prod_i, prod_d;
    logic [47:0] mag_p, mag_i, mag_d;

    assign mag_p = {30'd0, (err_reg < 0) ? 18'(-err_reg) : 18'(err_reg)};
    assign mag_i = (integ_reg < 0) ? 48'(-integ_reg) : 48'(integ_reg);
    assign mag_d = {32'd0, (gyro_reg < 0) ? 16'(-gyro_reg) : 16'(gyro_reg)};

    bpaw_mul u_mul_p (.aclk, .aresetn, .start(mul_start), .gain(p_gain_reg),
        .mag(mag_p), .done(done_p), .prod(prod_p));
    bpaw_mul u_mul_i (.aclk, .aresetn, .start(mul_start), .gain({4'd0, i_gain_reg}),
        .mag(mag_i), .done(done_i), .prod(prod_i));
    bpaw_mul u_mul_d (.aclk, .aresetn, .start(mul_start), .gain(d_gain_reg),
        .mag(mag_d), .done(done_d), .prod(prod_d));

    logic signed [64:0] sp, si, sd;
    logic signed [57:0] integ_sum;
    logic [64:0]        sum_mag;
    logic [15:0]        corr;
    logic               sat;
    logic signed [17:0] drv, left, right;
    logic signed [15:0] tgt, rl, atgt, arl;
    logic [16:0]        apitch;
    logic               restart;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) sat16 = 16'sh7fff;
        else if (v < -18'sd32768) sat16 = 16'sh8000;
        else sat16 = v[15:0];
    endfunction

    always_comb begin
        state_next  = state_reg;
        pitch_next  = pitch_reg;
        gyro_next   = gyro_reg;
        dt_next     = dt_reg;
        mode_next   = mode_reg;
        err_next    = err_reg;
        sum_next    = sum_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg;
        integ_next  = integ_reg;
        was_sat_next = was_sat_reg;
        same_next   = same_reg;
        target_next = target_reg;
        rlim_next   = rlim_reg;
        pmode_next  = pmode_reg;
        first_next  = first_reg;
        mul_start   = 1'b0;
        sp = (err_reg < 0) ? -$signed({4'd0, prod_p}) : $signed({4'd0, prod_p});
        si = (integ_reg < 0) ? -$signed({4'd0, prod_i}) : $signed({4'd0, prod_i});
        sd = (gyro_reg < 0) ? -$signed({4'd0, prod_d}) : $signed({4'd0, prod_d});
        integ_sum = 58'(integ_reg) + 58'(err_reg) * $signed({50'd0, dt_reg});
        sum_mag = (sum_reg < 0) ? 65'(-sum_reg) : 65'(sum_reg);
        sat  = sum_mag > {34'd0, clim_reg, 16'd0};
        corr = sat ? {1'b0, clim_reg} : 16'((sum_mag + 65'd32768) >> 16);
        drv  = (sum_reg > 0) ? $signed({2'b0, corr}) : -$signed({2'b0, corr});
        left = drv;
        right = drv;
        tgt = target_reg;
        rl = rlim_reg;
        atgt = 16'sd0;
        arl = 16'sd0;
        apitch = (pitch_reg < 0) ? 17'(-pitch_reg) : 17'(pitch_reg);
        restart = {1'b0, apitch} >= {2'b0, poff_reg};

        if (m_axis_tvalid && m_axis_tready) begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    pitch_next = s_axis_tdata[16:0];
                    gyro_next  = s_axis_tdata[32:17];
                    dt_next    = first_reg ? s_axis_tdata[40:33] : init_ms_reg;
                    mode_next  = s_axis_tdata[44:41];
                    first_next = 1'b1;
                    err_next   = 18'(target_reg) + 18'($signed(s_axis_tdata[16:0]));
                    state_next = ST_INT;
                end
            end
            ST_INT: begin
                if (!(was_sat_reg && same_reg)) begin
                    if (integ_sum > 58'(bpaw_pkg::INT_MAX48)) integ_next = bpaw_pkg::INT_MAX48;
                    else if (integ_sum < 58'(bpaw_pkg::INT_MIN48))
                        integ_next = bpaw_pkg::INT_MIN48;
                    else integ_next = integ_sum[47:0];
                end
                state_next = ST_MST;
            end
            ST_MST: begin
                mul_start = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (done_p) begin
                    sum_next = sp + si;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                sum_next = sum_reg + sd;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // hold here while the previous result still waits
                if (!ovalid_reg || m_axis_tready) begin
                    was_sat_next = sat;
                    same_next = (sum_reg > 0 && err_reg > 0) || (sum_reg < 0 && err_reg < 0);
                    if (mode_reg <= bpaw_pkg::MODE_BWD3) begin
                        rl = bpaw_pkg::ramp_limit(mode_reg);
                        if (pmode_reg != mode_reg) tgt = 16'sd0;
                        pmode_next = mode_reg;
                        atgt = (tgt < 0) ? -tgt : tgt;
                        arl  = (rl < 0) ? -rl : rl;
                        if (atgt < arl) tgt = tgt + rl / 4;
                        else tgt = rl;
                    end else if (mode_reg == bpaw_pkg::MODE_LEFT) begin
                        tgt = 16'sd0;
                        left  = drv - $signed({4'd0, turn_reg});
                        right = drv + $signed({4'd0, turn_reg});
                    end else if (mode_reg == bpaw_pkg::MODE_RIGHT) begin
                        tgt = 16'sd0;
                        left  = drv + $signed({4'd0, turn_reg});
                        right = drv - $signed({4'd0, turn_reg});
                    end else if (mode_reg == bpaw_pkg::MODE_STILL) begin
                        atgt = (tgt < 0) ? -tgt : tgt;
                        if (atgt <= bpaw_pkg::STILL_SNAP) tgt = 16'sd0;
                        else tgt = tgt - tgt / 4;
                    end
                    rlim_next = rl;
                    if (restart) begin
                        left = 18'sd0;
                        right = 18'sd0;
                        integ_next = '0;
                        was_sat_next = 1'b0;
                        same_next = 1'b0;
                        tgt = 16'sd0;
                    end
                    target_next = tgt;
                    out_next = {7'd0, restart, sat16(right), sat16(left)};
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!ovalid_reg) begin
                    ovalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_gain_reg  <= bpaw_pkg::P_GAIN_RST;
            i_gain_reg  <= bpaw_pkg::I_GAIN_RST;
            d_gain_reg  <= bpaw_pkg::D_GAIN_RST;
            clim_reg    <= bpaw_pkg::CLIM_RST;
            turn_reg    <= bpaw_pkg::TURN_RST;
            poff_reg    <= bpaw_pkg::POFF_RST;
            init_ms_reg <= bpaw_pkg::INIT_MS_RST;
            integ_reg   <= '0;
            was_sat_reg <= 1'b0;
            same_reg    <= 1'b0;
            target_reg  <= '0;
            rlim_reg    <= '0;
            pmode_reg   <= bpaw_pkg::MODE_STILL;
            first_reg   <= 1'b0;
            state_reg   <= ST_IDLE;
            ovalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    bpaw_pkg::REG_P_GAIN:  p_gain_reg  <= cfg_wdata;
                    bpaw_pkg::REG_I_GAIN:  i_gain_reg  <= cfg_wdata[19:0];
                    bpaw_pkg::REG_D_GAIN:  d_gain_reg  <= cfg_wdata;
                    bpaw_pkg::REG_CLIM:    clim_reg    <= cfg_wdata[14:0];
                    bpaw_pkg::REG_TURN:    turn_reg    <= cfg_wdata[13:0];
                    bpaw_pkg::REG_POFF:    poff_reg    <= cfg_wdata[15:0];
                    bpaw_pkg::REG_INIT_MS: init_ms_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            integ_reg   <= integ_next;
            was_sat_reg <= was_sat_next;
            same_reg    <= same_next;
            target_reg  <= target_next;
            rlim_reg    <= rlim_next;
            pmode_reg   <= pmode_next;
            first_reg   <= first_next;
            state_reg   <= state_next;
            ovalid_reg  <= ovalid_next;
        end
        pitch_reg <= pitch_next;
        gyro_reg  <= gyro_next;
        dt_reg    <= dt_next;
        mode_reg  <= mode_next;
        err_reg   <= err_next;
        sum_reg   <= sum_next;
        out_reg   <= out_next;
    end

    // done_i/done_d finish with done_p; all three start together
    logic mul_unused;
    assign mul_unused = done_i ^ done_d;

    assign s_axis_tready = (state_reg == ST_IDLE) && !mul_unused;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;
endmodule

// ----- bench/balance_pid_anti_windup_top_tb.sv -----
module balance_pid_anti_windup_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_PROD  = longint'(1) <<< 60;
    localparam longint ACC_MAX   = (longint'(1) <<< 47) - 1;
    localparam longint ACC_MIN   = -(longint'(1) <<< 47);
    localparam int     IDLE_MAX  = 5000;   // cycles without any transaction
    localparam int     DRAIN_CYC = 70;     // margin over the result latency
    localparam int     HOLD_CYC  = 300;    // long receiver stall

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               restarted;
    } drive_t;

    typedef struct {
        int     pitch;
        int     gyro;
        int     ms;
        int     mode;
        bit     typed;      // expected value typed in below
        drive_t want;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [16:0] pitch, [32:17] gyro_rate, [40:33] elapsed_ms, [44:41] mode
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [15:0] drive_left, [31:16] drive_right, [32] restarted
    logic [39:0] m_axis_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [23:0] cfg_wdata;

    balance_pid_anti_windup_top uut (.*);

    // mirror of the configuration registers
    logic [23:0] kp;
    logic [19:0] ki;
    logic [23:0] kd;
    logic [14:0] clim;
    logic [13:0] turn;
    logic [15:0] poff;
    logic [7:0]  init_ms;

    // mirror of the loop state
    longint      integ;
    bit          sat_last, same_last, started;
    int          target, ramp_lim;
    logic [3:0]  last_mode;

    drive_t      drive_q[$];
    int          fails;
    int          idle_cnt;
    bit          hold_req;
    bit          no_gaps;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint gain_mul(longint unsigned g, longint x);
        longint unsigned mag;
        longint          r;
        mag = (x < 0) ? longint'(-x) : longint'(x);
        if (g != 0 && mag > longint'(SAT_PROD) / g)
            r = SAT_PROD;
        else
            r = longint'(g * mag);
        return (x < 0) ? -r : r;
    endfunction

    function automatic int clip16(longint v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : int'(v));
    endfunction

    function automatic int mag32(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int ramp_limit_of(logic [3:0] m);
        case (m)
            4'd0, 4'd2: return -205;
            4'd1, 4'd3: return 384;
            4'd4:       return -640;
            default:    return 640;
        endcase
    endfunction

    // advances the mirrored state by one control tick
    function automatic drive_t balance_step(int pitch, int gyro, int ms, logic [3:0] mode);
        longint          err, nxt, sum, lft, rgt, corr, dt;
        longint unsigned mag, lim;
        drive_t          d;
        dt = started ? ms : init_ms;
        started = 1'b1;
        err = target + pitch;
        if (!(sat_last && same_last)) begin
            nxt = integ + err * dt;
            integ = (nxt > ACC_MAX) ? ACC_MAX : ((nxt < ACC_MIN) ? ACC_MIN : nxt);
        end
        sum = gain_mul(kp, err) + gain_mul(ki, integ) + gain_mul(kd, gyro);
        mag = (sum < 0) ? longint'(-sum) : longint'(sum);
        lim = longint'(clim) << 16;
        if (mag > lim) begin
            corr = clim;
            sat_last = 1'b1;
        end else begin
            corr = (mag + 32768) >> 16;
            sat_last = 1'b0;
        end
        same_last = (sum > 0 && err > 0) || (sum < 0 && err < 0);
        lft = (sum > 0) ? corr : -corr;
        rgt = lft;
        if (mode <= bpaw_pkg::MODE_BWD3) begin
            ramp_lim = ramp_limit_of(mode);
            if (last_mode != mode) target = 0;
            last_mode = mode;
            if (mag32(target) < mag32(ramp_lim))
                target += ramp_lim / 4;
            else
                target = ramp_lim;
        end else if (mode == bpaw_pkg::MODE_LEFT) begin
            target = 0;
            lft -= turn;
            rgt += turn;
        end else if (mode == bpaw_pkg::MODE_RIGHT) begin
            target = 0;
            lft += turn;
            rgt -= turn;
        end else if (mode == bpaw_pkg::MODE_STILL) begin
            if (mag32(target) <= 76)
                target = 0;
            else
                target -= target / 4;
        end
        d.restarted = (mag32(pitch) >= int'(poff));
        if (d.restarted) begin
            lft = 0;
            rgt = 0;
            integ = 0;
            sat_last = 1'b0;
            same_last = 1'b0;
            target = 0;
        end
        d.left  = 16'(clip16(lft));
        d.right = 16'(clip16(rgt));
        return d;
    endfunction

    // leaves cfg_we high; the caller drops it after the last write
    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            bpaw_pkg::REG_P_GAIN:  kp      = val;
            bpaw_pkg::REG_I_GAIN:  ki      = val[19:0];
            bpaw_pkg::REG_D_GAIN:  kd      = val;
            bpaw_pkg::REG_CLIM:    clim    = val[14:0];
            bpaw_pkg::REG_TURN:    turn    = val[13:0];
            bpaw_pkg::REG_POFF:    poff    = val[15:0];
            bpaw_pkg::REG_INIT_MS: init_ms = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_all(int p, int i, int d, int c, int t, int po, int im);
        write_reg(bpaw_pkg::REG_P_GAIN, 24'(p));
        write_reg(bpaw_pkg::REG_I_GAIN, 24'(i));
        write_reg(bpaw_pkg::REG_D_GAIN, 24'(d));
        write_reg(bpaw_pkg::REG_CLIM, 24'(c));
        write_reg(bpaw_pkg::REG_TURN, 24'(t));
        write_reg(bpaw_pkg::REG_POFF, 24'(po));
        write_reg(bpaw_pkg::REG_INIT_MS, 24'(im));
        cfg_we <= 1'b0;
    endtask

    // wait for every outstanding result, then let the block settle
    task automatic drain();
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (drive_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one tick; holds tvalid high into the next call when no gap follows
    task automatic send_tick(int pitch, int gyro, int ms, int mode, bit typed, drive_t want);
        int     gap;
        drive_t got;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b0, 4'(mode), 8'(ms), 16'(gyro), 17'(pitch)};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        got = balance_step(pitch, gyro, ms, 4'(mode));
        drive_q.push_back(typed ? want : got);
    endtask

    task automatic random_ticks(int n);
        int pitch, mode, r;
        drive_t none;
        none = '0;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                pitch = $urandom_range(0, 6000) - 3000;   // stays upright
            else
                pitch = $urandom_range(0, 92160) - 46080;
            r = $urandom_range(0, 99);
            if (r < 40)
                mode = last_mode;                         // hold a drive mode
            else if (r < 85)
                mode = $urandom_range(0, 8);
            else
                mode = $urandom_range(9, 15);
            send_tick(pitch, $urandom_range(0, 65535) - 32768, $urandom_range(0, 255),
                      mode, 1'b0, none);
            if (k == n / 2 && n > 100) hold_req = 1'b1;
        end
    endtask

    row_t rows[$];

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        fails = 0; hold_req = 1'b0; no_gaps = 1'b0;
        kp = bpaw_pkg::P_GAIN_RST; ki = bpaw_pkg::I_GAIN_RST; kd = bpaw_pkg::D_GAIN_RST;
        clim = bpaw_pkg::CLIM_RST; turn = bpaw_pkg::TURN_RST; poff = bpaw_pkg::POFF_RST;
        init_ms = bpaw_pkg::INIT_MS_RST;
        integ = 0; sat_last = 0; same_last = 0; started = 0;
        target = 0; ramp_lim = 0; last_mode = bpaw_pkg::MODE_STILL;

        // directed ticks: extremes, every mode, limit edge, windup, snap
        rows = '{
            '{0, 0, 0, 9, 1'b1, '{16'sd0, 16'sd0, 1'b0}},            // first tick, zero err
            '{46080, 32767, 255, 15, 1'b1, '{16'sd0, 16'sd0, 1'b1}},  // pitch max
            '{-46080, -32768, 0, 0, 1'b1, '{16'sd0, 16'sd0, 1'b1}},   // pitch min
            '{0, 0, 5, 6, 1'b1, '{-16'sd1000, 16'sd1000, 1'b0}},      // left turn from rest
            '{11520, 0, 5, 7, 1'b1, '{16'sd0, 16'sd0, 1'b1}},         // exactly at limit
            '{11519, 100, 5, 9, 1'b0, '{default: '0}},
            '{-11519, -100, 5, 10, 1'b0, '{default: '0}},
            '{10000, 0, 255, 9, 1'b0, '{default: '0}},                // drive into windup
            '{10000, 0, 255, 9, 1'b0, '{default: '0}},
            '{10000, 32767, 255, 9, 1'b0, '{default: '0}},
            '{-200, -32768, 1, 0, 1'b0, '{default: '0}},
            '{-200, 0, 1, 1, 1'b0, '{default: '0}},
            '{50, 0, 1, 2, 1'b0, '{default: '0}},
            '{50, 0, 1, 3, 1'b0, '{default: '0}},
            '{30, 0, 1, 4, 1'b0, '{default: '0}},
            '{30, 0, 1, 4, 1'b0, '{default: '0}},
            '{30, 0, 1, 5, 1'b0, '{default: '0}},
            '{30, 0, 1, 5, 1'b0, '{default: '0}},
            '{30, 0, 1, 5, 1'b0, '{default: '0}},
            '{30, 0, 1, 5, 1'b0, '{default: '0}},
            '{30, 0, 1, 5, 1'b0, '{default: '0}},                     // target pinned at limit
            '{0, 0, 1, 8, 1'b0, '{default: '0}},                      // still decays target
            '{0, 0, 1, 8, 1'b0, '{default: '0}},
            '{0, 0, 1, 8, 1'b0, '{default: '0}},
            '{0, 0, 1, 8, 1'b0, '{default: '0}}                       // target still above the snap threshold
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[j])
            send_tick(rows[j].pitch, rows[j].gyro, rows[j].ms, rows[j].mode,
                      rows[j].typed, rows[j].want);

        no_gaps = 1'b1;
        random_ticks(60);
        no_gaps = 1'b0;
        random_ticks(140);                          // includes the long stall

        drain();
        set_all(16777215, 1048575, 16777215, 32767, 16383, 46080, 255);
        random_ticks(90);

        drain();
        set_all(0, 0, 0, 0, 0, 0, 0);               // every tick restarts
        random_ticks(25);

        drain();
        set_all($urandom_range(0, 400000), $urandom_range(0, 8000), $urandom_range(0, 60000),
                $urandom_range(1, 32767), $urandom_range(0, 16383),
                $urandom_range(2000, 46080), $urandom_range(0, 255));
        random_ticks(90);

        drain();
        set_all(192000, 2304, 10240, 100, 16383, 20000, 3);   // small clamp, hard turns
        random_ticks(70);

        drain();
        if (fails == 0)
            $display("balance_pid_anti_windup_top_tb OK");
        else
            $display("balance_pid_anti_windup_top_tb NOT OK");
        $finish;
    end

    // receiver: random back-pressure, plus one long stall on request
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYC) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if ($urandom_range(0, 99) < 4)
                    m_axis_tready <= 1'b0;
                else
                    m_axis_tready <= ($urandom_range(0, 99) < 70);
                @(posedge aclk);
            end
        end
    end

    // result checker: each transaction against the oldest expectation
    always @(posedge aclk) begin
        drive_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (drive_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                fails++;
            end else begin
                want = drive_q.pop_front();
                if (m_axis_tdata[15:0] !== want.left) begin
                    $display("%0t: drive_left expected %0d actual %0d", $time,
                             want.left, $signed(m_axis_tdata[15:0]));
                    fails++;
                end
                if (m_axis_tdata[31:16] !== want.right) begin
                    $display("%0t: drive_right expected %0d actual %0d", $time,
                             want.right, $signed(m_axis_tdata[31:16]));
                    fails++;
                end
                if (m_axis_tdata[32] !== want.restarted) begin
                    $display("%0t: restarted expected %0d actual %0d", $time,
                             want.restarted, m_axis_tdata[32]);
                    fails++;
                end
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cnt <= 0;
        else if (idle_cnt >= IDLE_MAX) begin
            $display("%0t: watchdog expired", $time);
            $display("balance_pid_anti_windup_top_tb NOT OK");
            $finish;
        end else
            idle_cnt <= idle_cnt + 1;
    end

endmodule
